>>> rtl/lrutc_pkg.sv
// Package for the LRU tag cache with a failed-key list.
// Holds the sequencer state type, the result status codes and the scan unit control struct.
// No dependencies.
`timescale 1ns / 1ps

package lrutc_pkg;

    // Request kinds carried on the input tuser bit
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_HIT        = 3'd0,
        STAT_INSERTED   = 3'd1,
        STAT_FAILED     = 3'd2,
        STAT_KNOWN_FAIL = 3'd3,
        STAT_FLUSHED    = 3'd4
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FSCAN,
        ST_ESCAN,
        ST_DECIDE
    } state_t;

    // Control from the sequencer to the shared scan unit
    typedef struct packed {
        logic clear;
        logic fail_step;
        logic ent_step;
    } unit_ctrl_t;

endpackage

>>> rtl/lru_tag_cache_with_negative_list.sv
// Lookup: the failed-key list is scanned first, then the entries; a known-failed key
// skips the entry scan and a flush goes straight to the decision step. One stored element
// is walked per cycle through the shared scan unit; the next transaction is taken the
// cycle after the result is registered, so a new request waits for the previous result.
// Reset clears all valid bits and sets size_in_use to 16; tag, scale and age memories
// are not cleared and are only read under a valid bit.
`timescale 1ns / 1ps

module lru_tag_cache_with_negative_list
    import lrutc_pkg::*;
#(
    parameter int ENTRIES      = 16,
    parameter int FAILED_DEPTH = 16,
    parameter int TAG_WIDTH    = 32,
    parameter int AGE_WIDTH    = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: size_in_use
    input  logic        cfg_wen,
    input  logic [4:0]  cfg_wdata,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // key_tag[31:0], req_w[47:32], req_h[63:48],
                                   // load_ok[64], zero pad[71:65]
    input  logic        s_tuser,   // req_type[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // slot[3:0], evicted[4], evicted_tag[36:5], zero pad[39:37]
    output logic [2:0]  m_tuser    // status[2:0]
);

    localparam int EW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW     = (FAILED_DEPTH > 1) ? $clog2(FAILED_DEPTH) : 1;
    localparam int SCAN_N = (ENTRIES > FAILED_DEPTH) ? ENTRIES : FAILED_DEPTH;
    localparam int CW     = $clog2(SCAN_N + 1);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int REC_W  = TAG_WIDTH + 32;

    // Configuration register
    logic [4:0] size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= 5'd16;
        else if (cfg_wen)
            size_reg <= cfg_wdata;
    end

    // Sequencer state and scan counter
    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           rd_live_reg, rd_live_next;
    logic [CW-1:0]  rd_idx_reg, rd_idx_next;
    unit_ctrl_t     uctrl;
    logic           commit;
    logic           out_free;

    // Latched transaction
    logic                 req_reg;
    logic [TAG_WIDTH-1:0] key_reg;
    logic [15:0]          sw_reg;
    logic [15:0]          sh_reg;
    logic                 ok_reg;
    logic [TAG_WIDTH+31:0] key_ext;

    // Valid bits
    logic [ENTRIES-1:0]      ent_valid_reg;
    logic [FAILED_DEPTH-1:0] fail_valid_reg;

    // Memories and registered read data
    logic [REC_W-1:0]     rec_mem  [ENTRIES];
    logic [AGE_WIDTH-1:0] age_mem  [ENTRIES];
    logic [TAG_WIDTH-1:0] fail_mem [FAILED_DEPTH];
    logic [REC_W-1:0]     rec_rd_reg;
    logic [AGE_WIDTH-1:0] age_rd_reg;
    logic [TAG_WIDTH-1:0] fail_rd_reg;
    logic [EW-1:0]        ent_raddr;
    logic [FW-1:0]        fail_raddr;

    // Scan unit interface
    logic [TAG_WIDTH-1:0] u_tag_in;
    logic                 u_rd_valid;
    logic                 fail_hit, fail_free_found, hit_found, oldest_found, free_found;
    logic [FW-1:0]        fail_free_idx;
    logic [EW-1:0]        hit_idx, oldest_idx, free_idx;
    logic [TAG_WIDTH-1:0] oldest_tag;
    logic [CNT_W-1:0]     count;
    logic                 u_age_we;
    logic [AGE_WIDTH-1:0] u_age_next;

    // Decision
    logic [CNT_W-1:0]     limit;
    status_t              dec_status;
    logic [EW-1:0]        dec_slot;
    logic                 dec_ev;
    logic [TAG_WIDTH-1:0] dec_evtag;
    logic                 dec_ins;
    logic                 dec_fail_ins;
    logic [EW+3:0]        slot_ext;
    logic [TAG_WIDTH+31:0] evtag_ext;

    // Result register
    logic        m_tvalid_reg;
    status_t     status_reg;
    logic [3:0]  slot_reg;
    logic        ev_reg;
    logic [31:0] evtag_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign key_ext  = {{TAG_WIDTH{1'b0}}, s_tdata[31:0]};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = (s_tuser == REQ_FLUSH) ? ST_DECIDE : ST_FSCAN;
            end
            ST_FSCAN:
            begin
                if (cnt_reg == CW'(FAILED_DEPTH))
                    state_next = ST_ESCAN;
            end
            ST_ESCAN:
            begin
                if (fail_hit || (cnt_reg == CW'(ENTRIES)))
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready     = 1'b0;
        uctrl        = '0;
        cnt_next     = '0;
        rd_live_next = 1'b0;
        rd_idx_next  = cnt_reg;
        commit       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                uctrl.clear = s_tvalid;
            end
            ST_FSCAN:
            begin
                uctrl.fail_step = rd_live_reg;
                rd_live_next    = (cnt_reg < CW'(FAILED_DEPTH));
                if (cnt_reg != CW'(FAILED_DEPTH))
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_ESCAN:
            begin
                if (!fail_hit)
                begin
                    uctrl.ent_step = rd_live_reg;
                    rd_live_next   = (cnt_reg < CW'(ENTRIES));
                    if (cnt_reg != CW'(ENTRIES))
                        cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DECIDE:
            begin
                commit = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rd_live_reg <= 1'b0;
            rd_idx_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_live_reg <= rd_live_next;
            rd_idx_reg  <= rd_idx_next;
        end
    end

    // Transaction capture
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_reg <= s_tuser;
            key_reg <= key_ext[TAG_WIDTH-1:0];
            sw_reg  <= s_tdata[47:32];
            sh_reg  <= s_tdata[63:48];
            ok_reg  <= s_tdata[64];
        end
    end

    // Memory read side, one address per cycle from the scan counter
    assign ent_raddr  = cnt_reg[EW-1:0];
    assign fail_raddr = cnt_reg[FW-1:0];

    always_ff @(posedge clk)
    begin
        rec_rd_reg  <= rec_mem[ent_raddr];
        age_rd_reg  <= age_mem[ent_raddr];
        fail_rd_reg <= fail_mem[fail_raddr];
    end

    // Memory write side: age write-back during the entry scan, insertion on commit
    always_ff @(posedge clk)
    begin
        if (u_age_we)
            age_mem[rd_idx_reg[EW-1:0]] <= u_age_next;
        else if (commit && dec_ins)
            age_mem[dec_slot] <= '0;
        if (commit && dec_ins)
            rec_mem[dec_slot] <= {sh_reg, sw_reg, key_reg};
        if (commit && dec_fail_ins)
            fail_mem[fail_free_idx] <= key_reg;
    end

    // Operand selection into the shared unit
    assign u_tag_in   = (state_reg == ST_FSCAN) ? fail_rd_reg : rec_rd_reg[TAG_WIDTH-1:0];
    assign u_rd_valid = (state_reg == ST_FSCAN) ? fail_valid_reg[rd_idx_reg[FW-1:0]]
                                                : ent_valid_reg[rd_idx_reg[EW-1:0]];

    lrutc_unit #(
        .ENTRIES      (ENTRIES),
        .FAILED_DEPTH (FAILED_DEPTH),
        .TAG_WIDTH    (TAG_WIDTH),
        .AGE_WIDTH    (AGE_WIDTH)
    ) u_unit (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (uctrl),
        .key             (key_reg),
        .sw              (sw_reg),
        .sh              (sh_reg),
        .tag_in          (u_tag_in),
        .rd_sw           (rec_rd_reg[TAG_WIDTH+15:TAG_WIDTH]),
        .rd_sh           (rec_rd_reg[TAG_WIDTH+31:TAG_WIDTH+16]),
        .rd_age          (age_rd_reg),
        .rd_valid        (u_rd_valid),
        .rd_idx          (rd_idx_reg),
        .fail_hit        (fail_hit),
        .fail_free_found (fail_free_found),
        .fail_free_idx   (fail_free_idx),
        .hit_found       (hit_found),
        .hit_idx         (hit_idx),
        .oldest_found    (oldest_found),
        .oldest_idx      (oldest_idx),
        .oldest_tag      (oldest_tag),
        .free_found      (free_found),
        .free_idx        (free_idx),
        .count           (count),
        .age_we          (u_age_we),
        .age_next        (u_age_next)
    );

    // Effective size: zero counts as one, above ENTRIES counts as ENTRIES
    always_comb
    begin
        if (size_reg == 5'd0)
            limit = CNT_W'(1);
        else if (32'(size_reg) > 32'(ENTRIES))
            limit = CNT_W'(ENTRIES);
        else
            limit = CNT_W'(size_reg);
    end

    // Outcome of the scans
    always_comb
    begin
        dec_status   = STAT_HIT;
        dec_slot     = '0;
        dec_ev       = 1'b0;
        dec_evtag    = '0;
        dec_ins      = 1'b0;
        dec_fail_ins = 1'b0;
        if (req_reg == REQ_FLUSH)
        begin
            dec_status = STAT_FLUSHED;
        end
        else if (fail_hit)
        begin
            dec_status = STAT_KNOWN_FAIL;
        end
        else if (hit_found)
        begin
            dec_status = STAT_HIT;
            dec_slot   = hit_idx;
        end
        else if (!ok_reg)
        begin
            dec_status   = STAT_FAILED;
            dec_fail_ins = fail_free_found;
        end
        else
        begin
            dec_status = STAT_INSERTED;
            dec_ins    = 1'b1;
            dec_ev     = (count >= limit) && oldest_found;
            if (dec_ev)
            begin
                dec_slot  = oldest_idx;
                dec_evtag = oldest_tag;
            end
            else if (free_found)
            begin
                dec_slot = free_idx;
            end
        end
    end

    assign slot_ext  = {4'b0000, dec_slot};
    assign evtag_ext = {32'd0, dec_evtag};

    // Valid bits; an eviction keeps the slot valid and refills it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg  <= '0;
            fail_valid_reg <= '0;
        end
        else if (commit)
        begin
            if (req_reg == REQ_FLUSH)
            begin
                ent_valid_reg  <= '0;
                fail_valid_reg <= '0;
            end
            else
            begin
                if (dec_ins)
                    ent_valid_reg[dec_slot] <= 1'b1;
                if (dec_fail_ins)
                    fail_valid_reg[fail_free_idx] <= 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (commit)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg <= dec_status;
            slot_reg   <= slot_ext[3:0];
            ev_reg     <= dec_ev;
            evtag_reg  <= evtag_ext[31:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, evtag_reg, ev_reg, slot_reg};

    // A result only appears after the decision step
    a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == ST_DECIDE)
        else $error("result raised outside decision step");

    // Eviction is only reported with an insertion
    a_evict_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[4]) |-> (m_tuser == STAT_INSERTED))
        else $error("eviction reported without insertion");

    // A known-failed key never goes on to hit in the entry scan
    a_fail_excludes_hit: assert property (@(posedge clk) disable iff (!rst_n)
        fail_hit |-> !hit_found)
        else $error("failed-list hit and entry hit together");

endmodule

>>> rtl/lrutc_unit.sv
// Shared scan unit: one tag/scale comparator and one saturating age incrementer,
// stepped once per stored element, with the running trackers for hit, oldest and free slots.
// Depends on lrutc_pkg.
`timescale 1ns / 1ps

module lrutc_unit
    import lrutc_pkg::*;
#(
    parameter int ENTRIES      = 16,
    parameter int FAILED_DEPTH = 16,
    parameter int TAG_WIDTH    = 32,
    parameter int AGE_WIDTH    = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  unit_ctrl_t                    ctrl,
    input  logic [TAG_WIDTH-1:0]          key,
    input  logic [15:0]                   sw,
    input  logic [15:0]                   sh,
    input  logic [TAG_WIDTH-1:0]          tag_in,
    input  logic [15:0]                   rd_sw,
    input  logic [15:0]                   rd_sh,
    input  logic [AGE_WIDTH-1:0]          rd_age,
    input  logic                          rd_valid,
    input  logic [$clog2(((ENTRIES > FAILED_DEPTH) ? ENTRIES : FAILED_DEPTH) + 1)-1:0] rd_idx,
    output logic                          fail_hit,
    output logic                          fail_free_found,
    output logic [((FAILED_DEPTH > 1) ? $clog2(FAILED_DEPTH) : 1)-1:0] fail_free_idx,
    output logic                          hit_found,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] hit_idx,
    output logic                          oldest_found,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] oldest_idx,
    output logic [TAG_WIDTH-1:0]          oldest_tag,
    output logic                          free_found,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] free_idx,
    output logic [$clog2(ENTRIES + 1)-1:0] count,
    output logic                          age_we,
    output logic [AGE_WIDTH-1:0]          age_next
);

    localparam int EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW    = (FAILED_DEPTH > 1) ? $clog2(FAILED_DEPTH) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic                 fail_hit_reg, fail_hit_next;
    logic                 fail_free_found_reg, fail_free_found_next;
    logic [FW-1:0]        fail_free_idx_reg, fail_free_idx_next;
    logic                 hit_found_reg, hit_found_next;
    logic [EW-1:0]        hit_idx_reg, hit_idx_next;
    logic                 oldest_found_reg, oldest_found_next;
    logic [EW-1:0]        oldest_idx_reg, oldest_idx_next;
    logic [AGE_WIDTH-1:0] oldest_age_reg, oldest_age_next;
    logic [TAG_WIDTH-1:0] oldest_tag_reg, oldest_tag_next;
    logic                 free_found_reg, free_found_next;
    logic [EW-1:0]        free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    logic                 tag_eq;
    logic                 full_match;
    logic [AGE_WIDTH-1:0] aged;
    logic [EW-1:0]        e_idx;
    logic [FW-1:0]        f_idx;

    // Shared comparator and saturating incrementer
    assign tag_eq     = (tag_in == key);
    assign full_match = tag_eq && (rd_sw == sw) && (rd_sh == sh);
    assign aged       = (rd_age == {AGE_WIDTH{1'b1}}) ? rd_age : rd_age + 1'b1;
    assign e_idx      = rd_idx[EW-1:0];
    assign f_idx      = rd_idx[FW-1:0];

    // Tracker update for one element
    always_comb
    begin
        fail_hit_next        = fail_hit_reg;
        fail_free_found_next = fail_free_found_reg;
        fail_free_idx_next   = fail_free_idx_reg;
        hit_found_next       = hit_found_reg;
        hit_idx_next         = hit_idx_reg;
        oldest_found_next    = oldest_found_reg;
        oldest_idx_next      = oldest_idx_reg;
        oldest_age_next      = oldest_age_reg;
        oldest_tag_next      = oldest_tag_reg;
        free_found_next      = free_found_reg;
        free_idx_next        = free_idx_reg;
        count_next           = count_reg;
        age_we               = 1'b0;
        age_next             = aged;

        if (ctrl.clear)
        begin
            fail_hit_next        = 1'b0;
            fail_free_found_next = 1'b0;
            hit_found_next       = 1'b0;
            oldest_found_next    = 1'b0;
            free_found_next      = 1'b0;
            count_next           = '0;
        end
        else if (ctrl.fail_step)
        begin
            if (rd_valid)
            begin
                if (tag_eq)
                begin
                    fail_hit_next = 1'b1;
                end
            end
            else if (!fail_free_found_reg)
            begin
                fail_free_found_next = 1'b1;
                fail_free_idx_next   = f_idx;
            end
        end
        else if (ctrl.ent_step)
        begin
            if (rd_valid)
            begin
                count_next = count_reg + 1'b1;
                age_we     = 1'b1;
                if (!hit_found_reg && full_match)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = e_idx;
                    age_next       = '0;
                end
                else if (!oldest_found_reg || (aged > oldest_age_reg))
                begin
                    oldest_found_next = 1'b1;
                    oldest_idx_next   = e_idx;
                    oldest_age_next   = aged;
                    oldest_tag_next   = tag_in;
                end
            end
            else if (!free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = e_idx;
            end
        end
    end

    // Tracker registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_hit_reg        <= 1'b0;
            fail_free_found_reg <= 1'b0;
            fail_free_idx_reg   <= '0;
            hit_found_reg       <= 1'b0;
            hit_idx_reg         <= '0;
            oldest_found_reg    <= 1'b0;
            oldest_idx_reg      <= '0;
            oldest_age_reg      <= '0;
            oldest_tag_reg      <= '0;
            free_found_reg      <= 1'b0;
            free_idx_reg        <= '0;
            count_reg           <= '0;
        end
        else
        begin
            fail_hit_reg        <= fail_hit_next;
            fail_free_found_reg <= fail_free_found_next;
            fail_free_idx_reg   <= fail_free_idx_next;
            hit_found_reg       <= hit_found_next;
            hit_idx_reg         <= hit_idx_next;
            oldest_found_reg    <= oldest_found_next;
            oldest_idx_reg      <= oldest_idx_next;
            oldest_age_reg      <= oldest_age_next;
            oldest_tag_reg      <= oldest_tag_next;
            free_found_reg      <= free_found_next;
            free_idx_reg        <= free_idx_next;
            count_reg           <= count_next;
        end
    end

    assign fail_hit        = fail_hit_reg;
    assign fail_free_found = fail_free_found_reg;
    assign fail_free_idx   = fail_free_idx_reg;
    assign hit_found       = hit_found_reg;
    assign hit_idx         = hit_idx_reg;
    assign oldest_found    = oldest_found_reg;
    assign oldest_idx      = oldest_idx_reg;
    assign oldest_tag      = oldest_tag_reg;
    assign free_found      = free_found_reg;
    assign free_idx        = free_idx_reg;
    assign count           = count_reg;

endmodule
